### rtl/travel_time_position_estimator_assert.svh
// Assertion macros shared by the travel-time position estimator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TRAVEL_TIME_POSITION_ESTIMATOR_ASSERT_SVH
`define TRAVEL_TIME_POSITION_ESTIMATOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TTPE_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TTPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TTPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ttpe_pkg.sv
// Types and constants of the travel-time position estimator.
// No dependencies; used by the interfaces, the subtractor and the top level.
`default_nettype none

package ttpe_pkg;

  localparam int unsigned PosW  = 17;
  localparam int unsigned DurW  = 19;
  localparam int unsigned TimeW = 32;
  localparam int unsigned FracW = 16;

  localparam logic [PosW-1:0] PosOne = PosW'(1) << FracW;
  localparam int unsigned EdgeBandInt = (7 * (1 << FracW) + 999) / 1000;
  localparam logic [PosW-1:0] EdgeBand = PosW'(EdgeBandInt);
  localparam logic [PosW-1:0] EdgeHigh = PosOne - EdgeBand;

  localparam logic [DurW-1:0]  DefaultTravelMs = DurW'(20000);
  localparam logic [TimeW-1:0] MinTravelMs     = TimeW'(3000);
  localparam logic [TimeW-1:0] MaxTravelMs     = TimeW'(300000);

  typedef enum logic [2:0] {
    ACT_BEGIN    = 3'd0,
    ACT_ESTIMATE = 3'd1,
    ACT_FINISH   = 3'd2,
    ACT_CANCEL   = 3'd3,
    ACT_LOAD     = 3'd4
  } action_e;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [DurW-1:0]  dur_t;
  typedef logic [TimeW-1:0] time_t;

endpackage

`default_nettype wire

### rtl/ttpe_if.sv
// Request and response channels of the travel-time position estimator.
// Depends on ttpe_pkg for the field types.
`default_nettype none

interface ttpe_req_if import ttpe_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        direction;
  pos_t        start_position;
  time_t       now_ms;
  time_t       stored_open_ms;
  time_t       stored_close_ms;

  modport source (output valid, action, direction, start_position, now_ms,
                  stored_open_ms, stored_close_ms, input ready);
  modport sink (input valid, action, direction, start_position, now_ms,
                stored_open_ms, stored_close_ms, output ready);
endinterface

interface ttpe_rsp_if import ttpe_pkg::*; ();
  logic valid;
  logic ready;
  pos_t position;
  dur_t open_duration_ms;
  dur_t close_duration_ms;
  logic duration_updated;
  logic learning_open_active;
  logic learning_close_active;

  modport source (output valid, position, open_duration_ms, close_duration_ms,
                  duration_updated, learning_open_active, learning_close_active,
                  input ready);
  modport sink (input valid, position, open_duration_ms, close_duration_ms,
                duration_updated, learning_open_active, learning_close_active,
                output ready);
endinterface

`default_nettype wire

### rtl/ttpe_alu.sv
// Shared 32-bit subtractor with borrow, the arithmetic unit the estimator's sequencer steps on.
// Depends on ttpe_pkg for the word width.
`default_nettype none

module ttpe_alu import ttpe_pkg::*; (
  input  wire time_t a_i,
  input  wire time_t b_i,
  output time_t      diff_o,
  output logic       borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

`default_nettype wire

### rtl/travel_time_position_estimator.sv
// Top level of the travel-time position estimator: sequencer, state and result register.
// Depends on ttpe_pkg, ttpe_if.sv, ttpe_alu and the assertion macro header.
//
//   channel   dir  handshake       contents
//   req_i     in   valid/ready     action, direction, start, time, stored durations
//   rsp_o     out  valid/ready     position, durations, update and learning flags
//   cfg       in   write enable    auto_learn
//
// Estimate goes to the result register through one subtraction for the elapsed time,
// one compare, sixteen restoring division steps (skipped when elapsed >= duration)
// and one clamp step, all on the shared subtractor.
// Reset restores default durations of 20000 ms and enables learning.
// A result waits in its register until taken; a new request is accepted meanwhile.
`default_nettype none

module travel_time_position_estimator import ttpe_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  ttpe_req_if.sink   req_i,
  ttpe_rsp_if.source rsp_o,
  input  wire        auto_learn_we_i,
  input  wire        auto_learn_i
);

`include "travel_time_position_estimator_assert.svh"

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIFF = 11'b000_0000_0010,
    S_CMP  = 11'b000_0000_0100,
    S_DIV  = 11'b000_0000_1000,
    S_POS  = 11'b000_0001_0000,
    S_LOW  = 11'b000_0010_0000,
    S_HIGH = 11'b000_0100_0000,
    S_ABS  = 11'b000_1000_0000,
    S_NEG  = 11'b001_0000_0000,
    S_TEST = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e      state_q;
  logic        auto_learn_q;
  time_t       move_start_time_q;
  pos_t        move_start_pos_q;
  logic        learn_open_q, learn_close_q;
  time_t       learn_start_q;
  dur_t        open_ms_q, close_ms_q;

  logic [2:0]  act_q;
  logic        dir_q;
  pos_t        start_q;
  time_t       now_q, st_open_q, st_close_q;

  time_t       t_q;
  logic [DurW-1:0] rem_q;
  logic [DurW-1:0] mag_q;
  pos_t        delta_q;
  logic [3:0]  cnt_q;
  pos_t        pos_q;
  logic        upd_q;

  logic        rsp_valid_q;
  pos_t        rsp_pos_q;
  dur_t        rsp_open_q, rsp_close_q;
  logic        rsp_upd_q, rsp_lo_q, rsp_lc_q;

  time_t       alu_a, alu_b, alu_diff;
  logic        alu_borrow;
  dur_t        dur_sel;
  pos_t        start_sat;
  logic [21:0] mag_x10;
  logic        req_fire, rsp_load;

  assign dur_sel   = dir_q ? close_ms_q : open_ms_q;
  assign start_sat = (req_i.start_position > PosOne) ? PosOne : req_i.start_position;
  assign mag_x10   = {mag_q, 3'b000} + {2'b00, mag_q, 1'b0};
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_DIFF: begin
        alu_a = now_q;
        alu_b = (act_q == ACT_ESTIMATE) ? move_start_time_q : learn_start_q;
      end
      S_CMP: begin
        alu_a = t_q;
        alu_b = TimeW'(dur_sel);
      end
      S_DIV: begin
        alu_a = TimeW'({rem_q, 1'b0});
        alu_b = TimeW'(dur_sel);
      end
      S_POS: begin
        alu_a = dir_q ? TimeW'(move_start_pos_q) : TimeW'(PosOne - move_start_pos_q);
        alu_b = TimeW'(delta_q);
      end
      S_LOW: begin
        alu_a = t_q;
        alu_b = MinTravelMs;
      end
      S_HIGH: begin
        alu_a = MaxTravelMs;
        alu_b = t_q;
      end
      S_ABS: begin
        alu_a = t_q;
        alu_b = TimeW'(dur_sel);
      end
      S_NEG: begin
        alu_a = TimeW'(dur_sel);
        alu_b = t_q;
      end
      S_TEST: begin
        alu_a = TimeW'(dur_sel);
        alu_b = TimeW'(mag_x10);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  ttpe_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_learn_q <= 1'b1;
    end else if (auto_learn_we_i) begin
      auto_learn_q <= auto_learn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q      <= req_i.action;
      dir_q      <= req_i.direction;
      start_q    <= start_sat;
      now_q      <= req_i.now_ms;
      st_open_q  <= req_i.stored_open_ms;
      st_close_q <= req_i.stored_close_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      move_start_time_q <= '0;
      move_start_pos_q  <= '0;
      learn_open_q      <= 1'b0;
      learn_close_q     <= 1'b0;
      learn_start_q     <= '0;
      open_ms_q         <= DefaultTravelMs;
      close_ms_q        <= DefaultTravelMs;
      t_q               <= '0;
      rem_q             <= '0;
      mag_q             <= '0;
      delta_q           <= '0;
      cnt_q             <= '0;
      pos_q             <= '0;
      upd_q             <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            pos_q   <= '0;
            upd_q   <= 1'b0;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          t_q <= alu_diff;
          case (act_q)
            ACT_BEGIN: begin
              move_start_time_q <= now_q;
              move_start_pos_q  <= start_q;
              if (auto_learn_q && !dir_q && start_q <= EdgeBand) begin
                learn_open_q  <= 1'b1;
                learn_close_q <= 1'b0;
                learn_start_q <= now_q;
              end else if (auto_learn_q && dir_q && start_q >= EdgeHigh) begin
                learn_close_q <= 1'b1;
                learn_open_q  <= 1'b0;
                learn_start_q <= now_q;
              end
              state_q <= S_DONE;
            end
            ACT_ESTIMATE: begin
              state_q <= S_CMP;
            end
            ACT_FINISH: begin
              if (dir_q ? learn_close_q : learn_open_q) begin
                state_q <= S_LOW;
              end else begin
                learn_open_q      <= 1'b0;
                learn_close_q     <= 1'b0;
                learn_start_q     <= '0;
                move_start_time_q <= '0;
                state_q           <= S_DONE;
              end
            end
            ACT_CANCEL: begin
              learn_open_q      <= 1'b0;
              learn_close_q     <= 1'b0;
              learn_start_q     <= '0;
              move_start_time_q <= '0;
              state_q           <= S_DONE;
            end
            ACT_LOAD: begin
              if (st_open_q >= MinTravelMs && st_open_q <= MaxTravelMs) begin
                open_ms_q <= st_open_q[DurW-1:0];
              end
              if (st_close_q >= MinTravelMs && st_close_q <= MaxTravelMs) begin
                close_ms_q <= st_close_q[DurW-1:0];
              end
              state_q <= S_DONE;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_CMP: begin
          cnt_q <= '0;
          if (!alu_borrow) begin
            delta_q <= '1;
            state_q <= S_POS;
          end else begin
            rem_q   <= t_q[DurW-1:0];
            delta_q <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q   <= alu_borrow ? {rem_q[DurW-2:0], 1'b0} : alu_diff[DurW-1:0];
          delta_q <= {delta_q[PosW-2:0], ~alu_borrow};
          cnt_q   <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= S_POS;
          end
        end
        S_POS: begin
          if (dir_q) begin
            pos_q <= alu_borrow ? '0 : alu_diff[PosW-1:0];
          end else begin
            pos_q <= alu_borrow ? PosOne : PosOne - alu_diff[PosW-1:0];
          end
          state_q <= S_DONE;
        end
        S_LOW, S_HIGH: begin
          if (alu_borrow) begin
            learn_open_q      <= 1'b0;
            learn_close_q     <= 1'b0;
            learn_start_q     <= '0;
            move_start_time_q <= '0;
            state_q           <= S_DONE;
          end else begin
            state_q <= (state_q == S_LOW) ? S_HIGH : S_ABS;
          end
        end
        S_ABS: begin
          mag_q   <= alu_diff[DurW-1:0];
          state_q <= alu_borrow ? S_NEG : S_TEST;
        end
        S_NEG: begin
          mag_q   <= alu_diff[DurW-1:0];
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (alu_borrow || dur_sel == DefaultTravelMs) begin
            upd_q <= 1'b1;
            if (dir_q) begin
              close_ms_q <= t_q[DurW-1:0];
            end else begin
              open_ms_q <= t_q[DurW-1:0];
            end
          end
          learn_open_q      <= 1'b0;
          learn_close_q     <= 1'b0;
          learn_start_q     <= '0;
          move_start_time_q <= '0;
          state_q           <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_pos_q   <= pos_q;
      rsp_open_q  <= open_ms_q;
      rsp_close_q <= close_ms_q;
      rsp_upd_q   <= upd_q;
      rsp_lo_q    <= learn_open_q;
      rsp_lc_q    <= learn_close_q;
    end
  end

  assign rsp_o.valid                 = rsp_valid_q;
  assign rsp_o.position              = rsp_pos_q;
  assign rsp_o.open_duration_ms      = rsp_open_q;
  assign rsp_o.close_duration_ms     = rsp_close_q;
  assign rsp_o.duration_updated      = rsp_upd_q;
  assign rsp_o.learning_open_active  = rsp_lo_q;
  assign rsp_o.learning_close_active = rsp_lc_q;

  `TTPE_ASSERT_ALWAYS(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `TTPE_ASSERT_ALWAYS(a_learn_exclusive, clk_i, rst_ni, !(learn_open_q && learn_close_q))
  `TTPE_ASSERT_ALWAYS(a_open_in_range, clk_i, rst_ni,
                      TimeW'(open_ms_q) >= MinTravelMs && TimeW'(open_ms_q) <= MaxTravelMs)
  `TTPE_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, state_q == S_DIV && cnt_q == 4'd15,
                    state_q == S_POS)
  `TTPE_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_fire, !req_i.ready)

endmodule

`default_nettype wire
